// ----- hdl/msm_pkg.sv -----
// Shared constants, codes and the character map of the multi-pattern string matcher.
`default_nettype none
package msm_pkg;

   localparam int ALPHABET_DEF  = 62;
   localparam int MAX_NODES_DEF = 1024;

   localparam int OUT_NODE_W = 10;
   localparam int TOTAL_W    = 32;
   localparam int SYM_IDX_W  = 6;

   typedef logic [2:0] req_code_type;
   localparam req_code_type REQ_PAT_CHAR  = 3'd0;
   localparam req_code_type REQ_PAT_END   = 3'd1;
   localparam req_code_type REQ_TEXT_CHAR = 3'd2;
   localparam req_code_type REQ_TEXT_END  = 3'd3;
   localparam req_code_type REQ_CLEAR     = 3'd4;

   typedef logic [1:0] status_type;
   localparam status_type STAT_OK       = 2'd0;
   localparam status_type STAT_BAD_CHAR = 2'd1;
   localparam status_type STAT_FULL     = 2'd2;
   localparam status_type STAT_LOCKED   = 2'd3;

   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
   localparam logic [7:0] OFS_UPPER   = 8'd26;
   localparam logic [7:0] OFS_DIGIT   = 8'd52;

   // Returns {known, index}: a-z -> 0..25, A-Z -> 26..51, 0-9 -> 52..61.
   function automatic logic [SYM_IDX_W:0] map_symbol(input logic [7:0] b);
      logic [7:0] v;
      logic       ok;
      v  = '0;
      ok = 1'b0;
      if (b inside {[CHR_LOWER_A:CHR_LOWER_Z]}) begin
         v  = b - CHR_LOWER_A;
         ok = 1'b1;
      end else if (b inside {[CHR_UPPER_A:CHR_UPPER_Z]}) begin
         v  = b - CHR_UPPER_A + OFS_UPPER;
         ok = 1'b1;
      end else if (b inside {[CHR_DIGIT_0:CHR_DIGIT_9]}) begin
         v  = b - CHR_DIGIT_0 + OFS_DIGIT;
         ok = 1'b1;
      end
      return {ok, v[SYM_IDX_W-1:0]};
   endfunction

endpackage
`default_nettype wire

// ----- hdl/multi_pattern_string_matcher_core.sv -----
// Aho-Corasick matcher core: trie insert, automaton build and text scan.
`default_nettype none
// Aho-Corasick string matcher. Patterns are entered one character per request
// (pattern char, then pattern end) and grow a trie held in a goto memory of
// MAX_NODES*ALPHABET entries. The first text request builds the automaton in
// place: a breadth-first walk fills failure links, sums accept counts along
// them and completes every absent goto entry. Text chars then follow one goto
// entry each and add the node's accept count to a saturating 32-bit total;
// text end reports the total and starts a new text. One request is worked at
// a time, and every request returns exactly one response. Pattern chars wait
// on the registered read of the goto memory, text chars on the registered
// reads of the goto and then the accept-count memory, unless the request is
// locked, a bad character or part of an overflowed pattern; the core returns
// to idle after each response before the next request is taken, and a
// stalled response holds the core. The build first completes the root's goto
// entries, then for each queued trie node finds its failure link, adds the
// accept counts and walks its goto entries: each goto entry of the node is
// read, the matching entry of its failure link read, and the slot completed
// through the single goto memory port. A closing queue check ends the build.
// After reset and after a clear request the goto memory is swept to absent,
// one entry a cycle, over all MAX_NODES*ALPHABET entries (63488 at the
// defaults); no request is taken then.
module multi_pattern_string_matcher_core #(
   parameter int ALPHABET  = msm_pkg::ALPHABET_DEF,
   parameter int MAX_NODES = msm_pkg::MAX_NODES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [2:0]                  req_type,
   input  wire logic [7:0]                  req_symbol_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [msm_pkg::TOTAL_W-1:0]      rsp_match_total,
   output logic [msm_pkg::OUT_NODE_W-1:0]   rsp_current_node,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_text_done
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = NW + 1;
   localparam int SW  = $clog2(ALPHABET);
   localparam int GD  = MAX_NODES * ALPHABET;
   localparam int GAW = $clog2(GD);
   localparam int TW  = msm_pkg::TOTAL_W;
   localparam int ONW = msm_pkg::OUT_NODE_W;

   typedef enum logic [4:0] {
      ST_SWEEP, ST_IDLE, ST_EXEC, ST_RESULT,
      ST_P_RD, ST_P_CHK, ST_T_RD, ST_T_NODE, ST_T_ADD,
      ST_B_ROOT_RD, ST_B_ROOT_WR, ST_B_Q_CHK, ST_B_Q_U, ST_B_Q_P, ST_B_Q_F,
      ST_B_G1, ST_B_G2, ST_B_LK, ST_B_A2, ST_B_A3,
      ST_B_S_RD1, ST_B_S_RD2, ST_B_S_WR
   } state_type;

   state_type state_ff;

   // Memories.
   logic [NW:0]   goto_mem [GD];
   logic [CW-1:0] acc_mem  [MAX_NODES];
   logic [NW-1:0] fail_mem [MAX_NODES];
   logic [NW-1:0] pnode_mem [MAX_NODES];
   logic [SW-1:0] psym_mem [MAX_NODES];
   logic [NW-1:0] queue_mem [MAX_NODES];

   logic [NW:0]   g_rd_ff;
   logic [CW-1:0] acc_rd_ff;
   logic [NW-1:0] fail_rd_ff, pnode_rd_ff, q_rd_ff;
   logic [SW-1:0] psym_rd_ff;

   logic [GAW-1:0] g_ra, g_wa;
   logic           g_we;
   logic [NW:0]    g_wd;
   logic [NW-1:0]  acc_ra, acc_wa;
   logic           acc_we;
   logic [CW-1:0]  acc_wd;
   logic [NW-1:0]  fail_ra, fail_wa;
   logic           fail_we;
   logic [NW-1:0]  par_ra, par_wa;
   logic           par_we;
   logic [NW-1:0]  q_ra, q_wa, q_wd;
   logic           q_we;

   // Block state.
   logic [CW-1:0]  node_cnt_ff;
   logic           built_ff;
   logic [NW-1:0]  ins_cur_ff;
   logic           ins_fail_ff;
   logic [NW-1:0]  text_cur_ff;
   logic [TW-1:0]  total_ff;
   logic [GAW-1:0] sweep_ff;

   // Per-request and build working registers.
   logic [2:0]           typ_ff;
   logic [SW-1:0]        sym_ff;
   logic                 sym_ok_ff;
   msm_pkg::status_type  status_ff;
   logic [GAW-1:0]       addr_ff, ubase_ff, lbase_ff;
   logic [SW-1:0]        s_ff;
   logic [CW-1:0]        head_ff, tail_ff;
   logic [NW-1:0]        u_ff, lk_ff;
   logic [SW-1:0]        ps_ff;
   logic [CW-1:0]        acc_tmp_ff;
   logic [NW:0]          ent_ff;

   logic                 rsp_valid_ff;
   logic [TW-1:0]        rsp_total_ff;
   logic [ONW-1:0]       rsp_node_ff;
   msm_pkg::status_type  rsp_status_ff;
   logic                 rsp_done_ff;

   logic [msm_pkg::SYM_IDX_W:0] map_full;
   logic [SW-1:0]        map_raw;
   logic                 map_ok;
   logic                 full;
   logic                 out_free;
   logic [TW:0]          sum;
   logic [NW-1:0]        node_sel;
   logic [NW+ONW-1:0]    node_wide;

   assign map_full = msm_pkg::map_symbol(req_symbol_byte);
   assign map_raw  = SW'(map_full[msm_pkg::SYM_IDX_W-1:0]);
   assign map_ok   = map_full[msm_pkg::SYM_IDX_W]
                     && (32'(map_full[msm_pkg::SYM_IDX_W-1:0]) < 32'(ALPHABET));
   assign full     = (node_cnt_ff == CW'(MAX_NODES));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sum      = {1'b0, total_ff} + (TW + 1)'(acc_rd_ff);
   assign node_sel = (typ_ff == msm_pkg::REQ_TEXT_END) ? '0
                   : (built_ff ? text_cur_ff : ins_cur_ff);
   assign node_wide = {{ONW{1'b0}}, node_sel};

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_total  = rsp_total_ff;
   assign rsp_current_node = rsp_node_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_text_done    = rsp_done_ff;

   // Memory ports: one read and one write address per memory each cycle.
   always_comb begin
      g_ra    = addr_ff;
      g_wa    = addr_ff;
      g_we    = 1'b0;
      g_wd    = '0;
      acc_ra  = u_ff;
      acc_wa  = u_ff;
      acc_we  = 1'b0;
      acc_wd  = '0;
      fail_ra = pnode_rd_ff;
      fail_wa = u_ff;
      fail_we = 1'b0;
      par_ra  = q_rd_ff;
      par_wa  = node_cnt_ff[NW-1:0];
      par_we  = 1'b0;
      q_ra    = head_ff[NW-1:0];
      q_wa    = tail_ff[NW-1:0];
      q_wd    = '0;
      q_we    = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            g_we = 1'b1;
            g_wa = sweep_ff;
            if (sweep_ff < GAW'(MAX_NODES)) begin
               acc_we = 1'b1;
               acc_wa = sweep_ff[NW-1:0];
            end
         end
         ST_EXEC: begin
            // Mark the end of a pattern as accepting.
            if (typ_ff == msm_pkg::REQ_PAT_END && !built_ff && !ins_fail_ff) begin
               acc_we = 1'b1;
               acc_wa = ins_cur_ff;
               acc_wd = CW'(1);
            end
         end
         ST_P_CHK: begin
            if (!g_rd_ff[NW] && !full) begin
               g_we   = 1'b1;
               g_wd   = {1'b1, node_cnt_ff[NW-1:0]};
               acc_we = 1'b1;
               acc_wa = node_cnt_ff[NW-1:0];
               par_we = 1'b1;
            end
         end
         ST_T_NODE:    acc_ra = g_rd_ff[NW-1:0];
         ST_B_ROOT_RD: g_ra = GAW'(s_ff);
         ST_B_ROOT_WR: begin
            if (g_rd_ff[NW]) begin
               q_we = 1'b1;
               q_wd = g_rd_ff[NW-1:0];
            end else begin
               g_we = 1'b1;
               g_wa = GAW'(s_ff);
               g_wd = {1'b1, {NW{1'b0}}};
            end
         end
         ST_B_LK: begin
            fail_we = 1'b1;
            acc_ra  = lk_ff;
         end
         ST_B_A2: acc_ra = u_ff;
         ST_B_A3: begin
            acc_we = 1'b1;
            acc_wd = acc_rd_ff + acc_tmp_ff;
         end
         ST_B_S_RD1: g_ra = ubase_ff + GAW'(s_ff);
         ST_B_S_RD2: g_ra = lbase_ff + GAW'(s_ff);
         ST_B_S_WR: begin
            if (ent_ff[NW]) begin
               if (tail_ff < CW'(MAX_NODES)) begin
                  q_we = 1'b1;
                  q_wd = ent_ff[NW-1:0];
               end
            end else begin
               g_we = 1'b1;
               g_wa = ubase_ff + GAW'(s_ff);
               g_wd = g_rd_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (g_we) goto_mem[g_wa] <= g_wd;
      g_rd_ff <= goto_mem[g_ra];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      acc_rd_ff <= acc_mem[acc_ra];
   end

   always_ff @(posedge clock) begin
      if (fail_we) fail_mem[fail_wa] <= lk_ff;
      fail_rd_ff <= fail_mem[fail_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         pnode_mem[par_wa] <= ins_cur_ff;
         psym_mem[par_wa]  <= sym_ff;
      end
      pnode_rd_ff <= pnode_mem[par_ra];
      psym_rd_ff  <= psym_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_wa] <= q_wd;
      q_rd_ff <= queue_mem[q_ra];
   end

   // Control sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         node_cnt_ff  <= CW'(1);
         built_ff     <= 1'b0;
         ins_cur_ff   <= '0;
         ins_fail_ff  <= 1'b0;
         text_cur_ff  <= '0;
         total_ff     <= '0;
         typ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the response once it is taken; the result state reloads it itself.
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_RESULT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + GAW'(1);
               if (sweep_ff == GAW'(GD - 1)) begin
                  state_ff <= (typ_ff == msm_pkg::REQ_CLEAR) ? ST_RESULT : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  typ_ff    <= req_type;
                  sym_ff    <= map_raw;
                  sym_ok_ff <= map_ok;
                  status_ff <= msm_pkg::STAT_OK;
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               case (typ_ff)
                  msm_pkg::REQ_PAT_CHAR: begin
                     if (built_ff) begin
                        status_ff <= msm_pkg::STAT_LOCKED;
                        state_ff  <= ST_RESULT;
                     end else if (!sym_ok_ff) begin
                        status_ff <= msm_pkg::STAT_BAD_CHAR;
                        state_ff  <= ST_RESULT;
                     end else if (ins_fail_ff) begin
                        status_ff <= msm_pkg::STAT_FULL;
                        state_ff  <= ST_RESULT;
                     end else begin
                        addr_ff  <= GAW'(ins_cur_ff) * GAW'(ALPHABET) + GAW'(sym_ff);
                        state_ff <= ST_P_RD;
                     end
                  end
                  msm_pkg::REQ_PAT_END: begin
                     if (built_ff) begin
                        status_ff <= msm_pkg::STAT_LOCKED;
                     end else begin
                        if (ins_fail_ff) status_ff <= msm_pkg::STAT_FULL;
                        ins_cur_ff  <= '0;
                        ins_fail_ff <= 1'b0;
                     end
                     state_ff <= ST_RESULT;
                  end
                  msm_pkg::REQ_TEXT_CHAR, msm_pkg::REQ_TEXT_END: begin
                     if (!built_ff) begin
                        // Build first, then come back here.
                        built_ff    <= 1'b1;
                        ins_cur_ff  <= '0;
                        ins_fail_ff <= 1'b0;
                        s_ff        <= '0;
                        head_ff     <= '0;
                        tail_ff     <= '0;
                        state_ff    <= ST_B_ROOT_RD;
                     end else if (typ_ff == msm_pkg::REQ_TEXT_END) begin
                        state_ff <= ST_RESULT;
                     end else if (!sym_ok_ff) begin
                        status_ff <= msm_pkg::STAT_BAD_CHAR;
                        state_ff  <= ST_RESULT;
                     end else begin
                        addr_ff  <= GAW'(text_cur_ff) * GAW'(ALPHABET) + GAW'(sym_ff);
                        state_ff <= ST_T_RD;
                     end
                  end
                  msm_pkg::REQ_CLEAR: begin
                     node_cnt_ff <= CW'(1);
                     built_ff    <= 1'b0;
                     ins_cur_ff  <= '0;
                     ins_fail_ff <= 1'b0;
                     text_cur_ff <= '0;
                     total_ff    <= '0;
                     sweep_ff    <= '0;
                     state_ff    <= ST_SWEEP;
                  end
                  default: state_ff <= ST_RESULT;
               endcase
            end
            ST_P_RD: state_ff <= ST_P_CHK;
            ST_P_CHK: begin
               if (g_rd_ff[NW]) begin
                  ins_cur_ff <= g_rd_ff[NW-1:0];
               end else if (full) begin
                  ins_fail_ff <= 1'b1;
                  status_ff   <= msm_pkg::STAT_FULL;
               end else begin
                  ins_cur_ff  <= node_cnt_ff[NW-1:0];
                  node_cnt_ff <= node_cnt_ff + CW'(1);
               end
               state_ff <= ST_RESULT;
            end
            ST_T_RD: state_ff <= ST_T_NODE;
            ST_T_NODE: begin
               text_cur_ff <= g_rd_ff[NW-1:0];
               state_ff    <= ST_T_ADD;
            end
            ST_T_ADD: begin
               // Saturate the running total.
               total_ff <= sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
               state_ff <= ST_RESULT;
            end
            ST_B_ROOT_RD: state_ff <= ST_B_ROOT_WR;
            ST_B_ROOT_WR: begin
               if (g_rd_ff[NW]) tail_ff <= tail_ff + CW'(1);
               s_ff <= s_ff + SW'(1);
               state_ff <= (s_ff == SW'(ALPHABET - 1)) ? ST_B_Q_CHK : ST_B_ROOT_RD;
            end
            ST_B_Q_CHK: begin
               if (head_ff < tail_ff) begin
                  head_ff  <= head_ff + CW'(1);
                  state_ff <= ST_B_Q_U;
               end else begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_B_Q_U: begin
               u_ff     <= q_rd_ff;
               state_ff <= ST_B_Q_P;
            end
            ST_B_Q_P: begin
               ps_ff <= psym_rd_ff;
               if (pnode_rd_ff == '0) begin
                  lk_ff    <= '0;
                  state_ff <= ST_B_LK;
               end else begin
                  state_ff <= ST_B_Q_F;
               end
            end
            ST_B_Q_F: begin
               addr_ff  <= GAW'(fail_rd_ff) * GAW'(ALPHABET) + GAW'(ps_ff);
               state_ff <= ST_B_G1;
            end
            ST_B_G1: state_ff <= ST_B_G2;
            ST_B_G2: begin
               lk_ff    <= g_rd_ff[NW-1:0];
               state_ff <= ST_B_LK;
            end
            ST_B_LK: begin
               ubase_ff <= GAW'(u_ff) * GAW'(ALPHABET);
               lbase_ff <= GAW'(lk_ff) * GAW'(ALPHABET);
               state_ff <= ST_B_A2;
            end
            ST_B_A2: begin
               acc_tmp_ff <= acc_rd_ff;
               state_ff   <= ST_B_A3;
            end
            ST_B_A3: begin
               s_ff     <= '0;
               state_ff <= ST_B_S_RD1;
            end
            ST_B_S_RD1: state_ff <= ST_B_S_RD2;
            ST_B_S_RD2: begin
               ent_ff   <= g_rd_ff;
               state_ff <= ST_B_S_WR;
            end
            ST_B_S_WR: begin
               if (ent_ff[NW] && tail_ff < CW'(MAX_NODES)) tail_ff <= tail_ff + CW'(1);
               s_ff <= s_ff + SW'(1);
               state_ff <= (s_ff == SW'(ALPHABET - 1)) ? ST_B_Q_CHK : ST_B_S_RD1;
            end
            ST_RESULT: begin
               // Hold until the response register is free.
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_total_ff  <= total_ff;
                  rsp_node_ff   <= node_wide[ONW-1:0];
                  rsp_status_ff <= status_ff;
                  rsp_done_ff   <= (typ_ff == msm_pkg::REQ_TEXT_END);
                  if (typ_ff == msm_pkg::REQ_TEXT_END) begin
                     total_ff    <= '0;
                     text_cur_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of the Aho-Corasick string matcher core.
`default_nettype none
module tb;

   localparam int N_SYM     = msm_pkg::ALPHABET_DEF;
   localparam int N_NODES   = msm_pkg::MAX_NODES_DEF;
   localparam int N_SLOTS   = N_SYM * N_NODES;
   localparam int MAX_CYCLE = 4000000;
   localparam int END_WAIT  = 40;
   localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

   // one request as the sender holds it; hold makes the sender wait for an empty pipeline
   typedef struct {
      logic [2:0] kind;
      logic [7:0] sym;
      bit         hold;
   } match_req_type;

   typedef struct {
      logic [msm_pkg::TOTAL_W-1:0]    total;
      logic [msm_pkg::OUT_NODE_W-1:0] node;
      msm_pkg::status_type            status;
      logic                           done;
   } match_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_type = '0;
   logic [7:0] req_symbol_byte = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [msm_pkg::TOTAL_W-1:0] rsp_match_total;
   logic [msm_pkg::OUT_NODE_W-1:0] rsp_current_node;
   logic [1:0] rsp_status;
   logic rsp_text_done;

   match_req_type pending_reqs[$];
   match_rsp_type expected_rsps[$];
   int         n_total_reqs;
   int         n_sent = 0;
   int         n_errors = 0;
   int         cycle_count = 0;

   // shadow automaton
   bit               gt_valid [N_SLOTS];
   logic [9:0]       gt_node  [N_SLOTS];
   logic [9:0]       fail_lk  [N_NODES];
   logic [9:0]       par_node [N_NODES];
   int               par_sym  [N_NODES];
   int unsigned      acc_cnt  [N_NODES];
   logic [9:0]       walk_q   [N_NODES];
   int               n_nodes_used;
   bit               is_built;
   bit               ins_failed;
   logic [9:0]       ins_cur;
   logic [9:0]       txt_cur;
   logic [31:0]      run_total;

   always #10 clock = ~clock;

   multi_pattern_string_matcher_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_symbol_byte(req_symbol_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_match_total(rsp_match_total), .rsp_current_node(rsp_current_node),
      .rsp_status(rsp_status), .rsp_text_done(rsp_text_done)
   );

   // byte -> alphabet index, -1 when the byte is not a letter or digit
   function automatic int sym_index(logic [7:0] b);
      int v;
      if (b >= "a" && b <= "z") v = b - "a";
      else if (b >= "A" && b <= "Z") v = b - "A" + 26;
      else if (b >= "0" && b <= "9") v = b - "0" + 52;
      else return -1;
      return (v < N_SYM) ? v : -1;
   endfunction

   function automatic logic [7:0] index_char(int i);
      if (i < 26) return 8'("a" + i);
      if (i < 52) return 8'("A" + i - 26);
      return 8'("0" + i - 52);
   endfunction

   task automatic clear_automaton();
      for (int i = 0; i < N_SLOTS; i++) begin
         gt_valid[i] = 1'b0;
         gt_node[i] = '0;
      end
      for (int i = 0; i < N_NODES; i++) acc_cnt[i] = 0;
      n_nodes_used = 1;
      is_built = 1'b0;
      ins_failed = 1'b0;
      ins_cur = '0;
      txt_cur = '0;
      run_total = '0;
   endtask

   task automatic build_automaton();
      int head, tail, u, p, lk, s, k;
      head = 0;
      tail = 0;
      is_built = 1'b1;
      ins_cur = '0;
      ins_failed = 1'b0;
      fail_lk[0] = '0;
      for (s = 0; s < N_SYM; s++) begin
         if (gt_valid[s]) walk_q[tail++] = gt_node[s];
         else begin
            gt_valid[s] = 1'b1;
            gt_node[s] = '0;
         end
      end
      while (head < tail && head < N_NODES) begin
         u = walk_q[head++];
         p = par_node[u];
         if (p == 0) lk = 0;
         else lk = gt_node[fail_lk[p] * N_SYM + par_sym[u]];
         fail_lk[u] = 10'(lk);
         acc_cnt[u] += acc_cnt[lk];
         for (s = 0; s < N_SYM; s++) begin
            k = u * N_SYM + s;
            if (gt_valid[k]) begin
               if (tail < N_NODES) walk_q[tail++] = gt_node[k];
            end else begin
               gt_valid[k] = gt_valid[lk * N_SYM + s];
               gt_node[k] = gt_node[lk * N_SYM + s];
            end
         end
      end
   endtask

   // advance the shadow automaton by one request and return the response it owes
   task automatic predict_match(input match_req_type r, output match_rsp_type e);
      int si, k;
      logic [32:0] sum;
      e.status = msm_pkg::STAT_OK;
      e.done = 1'b0;
      case (r.kind)
         msm_pkg::REQ_PAT_CHAR: begin
            si = sym_index(r.sym);
            if (is_built) e.status = msm_pkg::STAT_LOCKED;
            else if (si < 0) e.status = msm_pkg::STAT_BAD_CHAR;
            else if (ins_failed) e.status = msm_pkg::STAT_FULL;
            else begin
               k = ins_cur * N_SYM + si;
               if (gt_valid[k]) ins_cur = gt_node[k];
               else if (n_nodes_used >= N_NODES) begin
                  ins_failed = 1'b1;
                  e.status = msm_pkg::STAT_FULL;
               end else begin
                  gt_valid[k] = 1'b1;
                  gt_node[k] = 10'(n_nodes_used);
                  par_node[n_nodes_used] = ins_cur;
                  par_sym[n_nodes_used] = si;
                  acc_cnt[n_nodes_used] = 0;
                  ins_cur = 10'(n_nodes_used);
                  n_nodes_used++;
               end
            end
         end
         msm_pkg::REQ_PAT_END: begin
            if (is_built) e.status = msm_pkg::STAT_LOCKED;
            else begin
               if (ins_failed) e.status = msm_pkg::STAT_FULL;
               else acc_cnt[ins_cur] = 1;
               ins_cur = '0;
               ins_failed = 1'b0;
            end
         end
         msm_pkg::REQ_TEXT_CHAR: begin
            if (!is_built) build_automaton();
            si = sym_index(r.sym);
            if (si < 0) e.status = msm_pkg::STAT_BAD_CHAR;
            else begin
               txt_cur = gt_node[txt_cur * N_SYM + si];
               sum = {1'b0, run_total} + 33'(acc_cnt[txt_cur]);
               run_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
         end
         msm_pkg::REQ_TEXT_END: begin
            if (!is_built) build_automaton();
            e.done = 1'b1;
         end
         msm_pkg::REQ_CLEAR: clear_automaton();
         default: ;
      endcase
      e.total = run_total;
      if (r.kind == msm_pkg::REQ_TEXT_END) begin
         run_total = '0;
         txt_cur = '0;
      end
      e.node = is_built ? txt_cur : ins_cur;
   endtask

   // idling profile follows how far the stimulus has progressed
   function automatic bit sender_idles();
      if (n_sent < n_total_reqs / 3) return $urandom_range(99) < 38;
      if (n_sent < 2 * n_total_reqs / 3) return $urandom_range(99) < 65;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      if (n_sent < n_total_reqs / 3) return $urandom_range(99) < 65;
      if (n_sent < 2 * n_total_reqs / 3) return $urandom_range(99) < 38;
      return 1'b0;
   endfunction

   // driver: hold the request until accepted, then predict and load the next one
   always @(posedge clock) begin
      match_rsp_type e;
      match_req_type cur;
      bit         took;
      if (!reset) begin
         took = req_valid && !req_stall;
         if (took) begin
            cur.kind = req_type;
            cur.sym = req_symbol_byte;
            cur.hold = 1'b0;
            predict_match(cur, e);
            expected_rsps = {expected_rsps, e};
         end
         if (req_valid && !took) begin
            // keep the stalled request as it is
         end else if (pending_reqs.size() != 0 && !sender_idles() &&
                      !(pending_reqs[0].hold && (took || expected_rsps.size() != 0))) begin
            cur = pending_reqs.pop_front();
            req_type <= cur.kind;
            req_symbol_byte <= cur.sym;
            req_valid <= 1'b1;
            n_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      match_rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected response total=%0d node=%0d",
                                            rsp_match_total, rsp_current_node);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_match_total !== e.total || rsp_current_node !== e.node ||
                   rsp_status !== e.status || rsp_text_done !== e.done) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("mismatch: exp %0d %0d st=%0d done=%0d, got %0d %0d %0d %0d",
                              e.total, e.node, e.status, e.done, rsp_match_total,
                              rsp_current_node, rsp_status, rsp_text_done);
               end
            end
         end
         rsp_stall <= receiver_stalls();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic add_req(logic [2:0] kind, logic [7:0] sym, bit hold = 1'b0);
      match_req_type r;
      r.kind = kind;
      r.sym = sym;
      r.hold = hold;
      pending_reqs = {pending_reqs, r};
   endtask

   function automatic logic [7:0] narrow_char();
      string pool;
      pool = "abcAZ09";
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   task automatic add_directed();
      // overlapping patterns, an empty pattern, bad bytes and the extremes of the map
      add_req(msm_pkg::REQ_PAT_CHAR, "a");
      add_req(msm_pkg::REQ_PAT_CHAR, "b");
      add_req(msm_pkg::REQ_PAT_END, 8'h00);
      add_req(msm_pkg::REQ_PAT_CHAR, "b");
      add_req(msm_pkg::REQ_PAT_END, 8'hFF);
      add_req(msm_pkg::REQ_PAT_END, "a");
      add_req(msm_pkg::REQ_PAT_CHAR, 8'h00);
      add_req(msm_pkg::REQ_PAT_CHAR, 8'hFF);
      add_req(msm_pkg::REQ_PAT_CHAR, "Z");
      add_req(msm_pkg::REQ_PAT_CHAR, "9");
      add_req(msm_pkg::REQ_PAT_END, "0");
      add_req(msm_pkg::REQ_PAT_CHAR, "A");
      add_req(msm_pkg::REQ_TEXT_CHAR, "a");
      add_req(msm_pkg::REQ_TEXT_CHAR, "b");
      add_req(msm_pkg::REQ_TEXT_CHAR, "Z");
      add_req(msm_pkg::REQ_TEXT_CHAR, "9");
      add_req(msm_pkg::REQ_TEXT_CHAR, "!");
      add_req(msm_pkg::REQ_TEXT_CHAR, "z");
      add_req(msm_pkg::REQ_TEXT_CHAR, "0");
      add_req(msm_pkg::REQ_TEXT_END, 8'h00);
      add_req(msm_pkg::REQ_PAT_CHAR, "a");
      add_req(msm_pkg::REQ_PAT_END, 8'h00);
      add_req(REQ_UNUSED_LO, 8'hA5);
      add_req(REQ_UNUSED_MID, 8'h5A);
      add_req(REQ_UNUSED_HI, 8'hFF);
   endtask

   // fill the node table with long patterns, then overrun it
   task automatic add_table_fill();
      int chars;
      add_req(msm_pkg::REQ_CLEAR, 8'h00, 1'b1);
      chars = 0;
      while (chars < 1060) begin
         repeat ($urandom_range(40, 60)) begin
            add_req(msm_pkg::REQ_PAT_CHAR, index_char($urandom_range(N_SYM - 1)));
            chars++;
         end
         add_req(msm_pkg::REQ_PAT_END, 8'(($urandom)));
      end
      repeat (3) add_req(msm_pkg::REQ_PAT_CHAR, index_char($urandom_range(N_SYM - 1)));
      add_req(msm_pkg::REQ_PAT_END, 8'h00);
      repeat (20) add_req(msm_pkg::REQ_TEXT_CHAR, index_char($urandom_range(N_SYM - 1)));
      add_req(msm_pkg::REQ_TEXT_END, 8'h00);
   endtask

   task automatic add_random_round();
      int pick;
      add_req(msm_pkg::REQ_CLEAR, 8'(($urandom)), 1'b1);
      repeat ($urandom_range(2, 10)) begin
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(9) == 0) add_req(msm_pkg::REQ_PAT_CHAR, 8'(($urandom)));
            else add_req(msm_pkg::REQ_PAT_CHAR, narrow_char());
         end
         add_req(msm_pkg::REQ_PAT_END, 8'(($urandom)));
      end
      repeat ($urandom_range(40, 120)) begin
         pick = $urandom_range(99);
         if (pick < 72) add_req(msm_pkg::REQ_TEXT_CHAR, narrow_char());
         else if (pick < 80) add_req(msm_pkg::REQ_TEXT_END, 8'(($urandom)));
         else if (pick < 88) add_req(msm_pkg::REQ_TEXT_CHAR, 8'(($urandom)));
         else if (pick < 93) add_req(msm_pkg::REQ_PAT_CHAR, narrow_char());
         else if (pick < 96) add_req(msm_pkg::REQ_PAT_END, 8'(($urandom)));
         else add_req(3'($urandom_range(int'(REQ_UNUSED_LO), int'(REQ_UNUSED_HI))),
                      8'(($urandom)));
      end
      add_req(msm_pkg::REQ_TEXT_END, 8'h00, $urandom_range(1));
   endtask

   initial begin
      clear_automaton();
      add_directed();
      // clear, then a build discards a partial pattern
      add_req(msm_pkg::REQ_CLEAR, 8'h00);
      add_req(msm_pkg::REQ_PAT_CHAR, "x");
      add_req(msm_pkg::REQ_TEXT_END, 8'h00);
      add_table_fill();
      add_random_round();
      n_total_reqs = pending_reqs.size();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
